>>> rtl/wcc_pkg.sv
// shared constants and types for the waveform character classifier
package wcc_pkg;

   localparam int LEVEL_W    = 7;
   localparam int DELTA_W    = 8;
   localparam int MAX_FRAME  = 1024;
   localparam int IDX_W      = $clog2(MAX_FRAME);
   localparam int CNT_W      = IDX_W + 1;
   localparam int Q16_SHIFT  = 16;
   localparam int SCALE_SHIFT = 10;
   localparam int LINE_W     = 26;
   localparam int BAD_W      = CNT_W;

   localparam int NOISE_W    = 17;
   localparam int CLEAN_W    = 13;
   localparam int DIST_W     = 18;
   localparam int LINEAR_W   = 12;
   localparam int TRI_W      = 11;

   localparam int DIV_W      = DIST_W + SCALE_SHIFT;
   localparam int DIVISOR_W  = CNT_W;
   localparam int DIV_LANES  = 5;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_NOISE_JUMP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTH_SLOPE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DISTORTION   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRI_SPAN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TRI_DROP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_TOL     = 3'd5;

   localparam logic [6:0] RST_NOISE_JUMP   = 7'd5;
   localparam logic [6:0] RST_SMOOTH_SLOPE = 7'd3;
   localparam logic [7:0] RST_DISTORTION   = 8'd3;
   localparam logic [9:0] RST_TRI_SPAN     = 10'd30;
   localparam logic [6:0] RST_TRI_DROP     = 7'd3;
   localparam logic [6:0] RST_LINE_TOL     = 7'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_MID = 7'd50;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 7'd100;
   localparam logic [CLEAN_W-1:0] CLEAN_STRONG = 13'd6;
   localparam logic [CLEAN_W-1:0] CLEAN_WEAK   = 13'd1;
   localparam logic [LINEAR_W-1:0] LINEAR_STEP = 12'd3;

   localparam int LANE_NOISE  = 0;
   localparam int LANE_CLEAN  = 1;
   localparam int LANE_DIST   = 2;
   localparam int LANE_LINEAR = 3;
   localparam int LANE_TRI    = 4;

   typedef logic [DIV_LANES-1:0][DIV_W-1:0] div_lanes_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/wcc_if.sv
// handshake channels for sample beats and score beats
interface wcc_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] level;
   logic       last_of_frame;
   modport source (output valid, level, last_of_frame, input ready);
   modport sink   (input valid, level, last_of_frame, output ready);
endinterface

interface wcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] noise_score;
   logic [12:0] clean_score;
   logic [17:0] distortion_score;
   logic [11:0] linear_score;
   logic [10:0] triangle_score;
   modport source (output valid, noise_score, clean_score, distortion_score, linear_score,
                   triangle_score, input ready);
   modport sink   (input valid, noise_score, clean_score, distortion_score, linear_score,
                   triangle_score, output ready);
endinterface

>>> rtl/wcc_divider.sv
// multi-lane restoring divider with one shared divisor, one quotient bit per cycle
module wcc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  wcc_pkg::div_lanes_type dividend,
   input  logic [wcc_pkg::DIVISOR_W-1:0] divisor,
   output wcc_pkg::div_lanes_type quotient,
   output wcc_pkg::div_status_type status
);
   import wcc_pkg::*;

   div_lanes_type                         work_ff, work_in;
   logic [DIV_LANES-1:0][DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]                  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                                  done_ff, done_in;
   logic [DIVISOR_W:0]                    trial;

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            trial = {rem_ff[l], work_ff[l][DIV_W-1]};
            if (trial >= {1'b0, dvs_ff}) begin
               trial = trial - {1'b0, dvs_ff};
               work_in[l] = {work_ff[l][DIV_W-2:0], 1'b1};
            end else begin
               work_in[l] = {work_ff[l][DIV_W-2:0], 1'b0};
            end
            rem_in[l] = trial[DIVISOR_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient    = work_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

>>> rtl/waveform_character_classifier_top.sv
// waveform character classifier top level: sample scoring, frame store, slope walk
// A rise that ends a qualifying falling slope starts the Q16 slope division and then the line
// walk, which reads the frame store memory one entry per cycle. The last beat of a frame
// starts the five parallel score divisions (one quotient bit per cycle) and then loads the
// score register; the next frame's first beat is taken while that score beat waits.
module waveform_character_classifier_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [wcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wcc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   wcc_req_if.sink                         req_ch,
   wcc_rsp_if.source                       rsp_ch
);
   import wcc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SLOPE = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_SCORE = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [6:0] noise_lim_ff, smooth_lim_ff, drop_lim_ff, tol_ff;
   logic [7:0] dist_lim_ff;
   logic [9:0] span_lim_ff;

   logic [2:0] state_ff, state_in;
   logic [LEVEL_W-1:0] last_level_ff, last_level_in;
   logic signed [DELTA_W-1:0] last_delta_ff, last_delta_in, older_delta_ff, older_delta_in;
   logic [NOISE_W-1:0]  noise_sum_ff, noise_sum_in;
   logic [CLEAN_W-1:0]  clean_sum_ff, clean_sum_in;
   logic [DIST_W-1:0]   dist_sum_ff, dist_sum_in;
   logic [LINEAR_W-1:0] linear_sum_ff, linear_sum_in;
   logic [TRI_W-1:0]    tri_cnt_ff, tri_cnt_in;
   logic [CNT_W-1:0]    sample_idx_ff, sample_idx_in;
   logic [LEVEL_W-1:0]  peak_lvl_ff, peak_lvl_in, trough_lvl_ff, trough_lvl_in;
   logic [IDX_W-1:0]    peak_idx_ff, peak_idx_in, trough_idx_ff, trough_idx_in;
   logic                fall_seen_ff, fall_seen_in;
   logic                last_pend_ff, last_pend_in;
   logic [LEVEL_W-1:0]  t_peak_ff, t_peak_in;
   logic [6:0]          t_drop_ff, t_drop_in;
   logic [IDX_W-1:0]    walk_k_ff, walk_k_in;
   logic                walk_issue_ff, walk_issue_in, walk_vld_ff, walk_vld_in;
   logic signed [LINE_W-1:0] y_ff, y_in;
   logic [BAD_W-1:0]    bad_ff, bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NOISE_W-1:0]  rsp_noise_ff;
   logic [CLEAN_W-1:0]  rsp_clean_ff;
   logic [DIST_W-1:0]   rsp_dist_ff;
   logic [LINEAR_W-1:0] rsp_linear_ff;
   logic [TRI_W-1:0]    rsp_tri_ff;
   logic                rsp_load;

   logic [LEVEL_W-1:0]  frame_mem [MAX_FRAME];
   logic [LEVEL_W-1:0]  rd_data_ff;
   logic                store_we;

   logic                accept, take, rise, fall;
   logic signed [DELTA_W-1:0] delta;
   logic [DELTA_W-1:0]  mag, abs_last, abs_older, change;
   logic signed [DELTA_W:0] chg_s;
   logic signed [CNT_W-1:0] span_s;
   logic signed [DELTA_W-1:0] drop_s;
   logic                qualify;
   logic signed [LINE_W-1:0] y_next, diff, tol_q;
   logic [BAD_W+1:0]    tri_lhs;

   logic                div_start;
   div_lanes_type       div_dvd, div_quot;
   logic [DIVISOR_W-1:0] div_dvs;
   div_status_type      div_stat;

   wcc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quot),
      .status   (div_stat)
   );

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign take = !sample_idx_ff[CNT_W-1];
   assign store_we = accept && take;

   // per-sample differences
   always_comb begin
      delta     = $signed({1'b0, last_level_ff}) - $signed({1'b0, req_ch.level});
      mag       = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
      abs_last  = last_delta_ff[DELTA_W-1] ? DELTA_W'(-last_delta_ff) : DELTA_W'(last_delta_ff);
      abs_older = older_delta_ff[DELTA_W-1] ? DELTA_W'(-older_delta_ff)
                                             : DELTA_W'(older_delta_ff);
      chg_s     = {last_delta_ff[DELTA_W-1], last_delta_ff} - {delta[DELTA_W-1], delta};
      change    = chg_s[DELTA_W] ? DELTA_W'(-chg_s) : chg_s[DELTA_W-1:0];
      rise      = req_ch.level > last_level_ff;
      fall      = req_ch.level < last_level_ff;
      span_s    = $signed({1'b0, trough_idx_ff}) - $signed({1'b0, peak_idx_ff});
      drop_s    = $signed({1'b0, peak_lvl_ff}) - $signed({1'b0, trough_lvl_ff});
      qualify   = !span_s[CNT_W-1] && (span_s[IDX_W-1:0] > span_lim_ff) &&
                  !drop_s[DELTA_W-1] && (drop_s[6:0] > drop_lim_ff);
      y_next    = y_ff - $signed({3'b000, div_quot[0][LINE_W-4:0]});
      diff      = y_next - $signed({3'b000, rd_data_ff, Q16_SHIFT'(0)});
      tol_q     = $signed({3'b000, tol_ff, Q16_SHIFT'(0)});
      tri_lhs   = {1'b0, bad_ff, 1'b0} + {2'b00, bad_ff} + (BAD_W+2)'(3);
   end

   // divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = {1'b0, span_s[IDX_W-1:0]};
      if (state_ff == ST_SCORE) begin
         div_start = 1'b1;
         div_dvd[LANE_NOISE]  = DIV_W'({noise_sum_ff, SCALE_SHIFT'(0)});
         div_dvd[LANE_CLEAN]  = DIV_W'({clean_sum_ff, SCALE_SHIFT'(0)});
         div_dvd[LANE_DIST]   = DIV_W'({dist_sum_ff, SCALE_SHIFT'(0)});
         div_dvd[LANE_LINEAR] = DIV_W'({linear_sum_ff, SCALE_SHIFT'(0)});
         div_dvd[LANE_TRI]    = DIV_W'({tri_cnt_ff, SCALE_SHIFT'(0)});
         div_dvs = sample_idx_ff;
      end else begin
         div_start  = accept && take && rise && fall_seen_ff && qualify;
         div_dvd[0] = DIV_W'({drop_s[6:0], Q16_SHIFT'(0)});
      end
   end

   always_comb begin
      state_in       = state_ff;
      last_level_in  = last_level_ff;
      last_delta_in  = last_delta_ff;
      older_delta_in = older_delta_ff;
      noise_sum_in   = noise_sum_ff;
      clean_sum_in   = clean_sum_ff;
      dist_sum_in    = dist_sum_ff;
      linear_sum_in  = linear_sum_ff;
      tri_cnt_in     = tri_cnt_ff;
      sample_idx_in  = sample_idx_ff;
      peak_lvl_in    = peak_lvl_ff;
      trough_lvl_in  = trough_lvl_ff;
      peak_idx_in    = peak_idx_ff;
      trough_idx_in  = trough_idx_ff;
      fall_seen_in   = fall_seen_ff;
      last_pend_in   = last_pend_ff;
      t_peak_in      = t_peak_ff;
      t_drop_in      = t_drop_ff;
      walk_k_in      = walk_k_ff;
      walk_issue_in  = 1'b0;
      walk_vld_in    = 1'b0;
      y_in           = y_ff;
      bad_in         = bad_ff;
      rsp_load       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_pend_in = req_ch.last_of_frame;
               state_in = req_ch.last_of_frame ? ST_SCORE : ST_IDLE;
               if (take) begin
                  sample_idx_in = sample_idx_ff + 1'b1;
                  if (mag[6:0] > noise_lim_ff) begin
                     noise_sum_in = noise_sum_ff + NOISE_W'(mag);
                  end else if (delta[DELTA_W-1] == last_delta_ff[DELTA_W-1]) begin
                     if (abs_last[6:0] <= smooth_lim_ff && abs_older[6:0] <= smooth_lim_ff &&
                         delta[DELTA_W-1] == older_delta_ff[DELTA_W-1]) begin
                        clean_sum_in = clean_sum_ff + CLEAN_STRONG;
                     end else begin
                        clean_sum_in = clean_sum_ff + CLEAN_WEAK;
                     end
                  end
                  if (change > dist_lim_ff) begin
                     dist_sum_in = dist_sum_ff + DIST_W'(change);
                  end
                  if (delta == last_delta_ff && last_delta_ff == older_delta_ff) begin
                     linear_sum_in = linear_sum_ff + LINEAR_STEP;
                  end
                  if (rise && !fall_seen_ff) begin
                     peak_idx_in = sample_idx_ff[IDX_W-1:0];
                     peak_lvl_in = req_ch.level;
                  end else if (fall) begin
                     trough_idx_in = sample_idx_ff[IDX_W-1:0];
                     trough_lvl_in = req_ch.level;
                     fall_seen_in  = 1'b1;
                  end else if (rise) begin
                     fall_seen_in  = 1'b0;
                     trough_lvl_in = LEVEL_TOP;
                     peak_lvl_in   = '0;
                     if (qualify) begin
                        t_peak_in = peak_lvl_ff;
                        t_drop_in = drop_s[6:0];
                        state_in  = ST_SLOPE;
                     end
                  end
                  older_delta_in = last_delta_ff;
                  last_delta_in  = delta;
                  last_level_in  = req_ch.level;
               end
            end
         end
         ST_SLOPE: begin
            if (div_stat.done) begin
               walk_k_in     = peak_idx_ff;
               walk_issue_in = 1'b1;
               y_in          = $signed({3'b000, t_peak_ff, Q16_SHIFT'(0)});
               bad_in        = '0;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            walk_vld_in = walk_issue_ff;
            if (walk_issue_ff) begin
               walk_issue_in = (walk_k_ff != trough_idx_ff);
               walk_k_in     = walk_k_ff + 1'b1;
            end
            if (walk_vld_ff) begin
               y_in = y_next;
               if (diff > tol_q || diff < -tol_q) begin
                  bad_in = bad_ff + 1'b1;
               end
            end
            if (!walk_issue_ff && !walk_vld_ff) begin
               if (tri_lhs <= (BAD_W+2)'(t_drop_ff)) begin
                  tri_cnt_in = tri_cnt_ff + 1'b1;
               end
               state_in = last_pend_ff ? ST_SCORE : ST_IDLE;
            end
         end
         ST_SCORE: begin
            noise_sum_in  = '0;
            clean_sum_in  = '0;
            dist_sum_in   = '0;
            linear_sum_in = '0;
            tri_cnt_in    = '0;
            sample_idx_in = '0;
            peak_lvl_in   = '0;
            trough_lvl_in = LEVEL_TOP;
            peak_idx_in   = '0;
            trough_idx_in = '0;
            fall_seen_in  = 1'b0;
            last_pend_in  = 1'b0;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_lim_ff  <= RST_NOISE_JUMP;
         smooth_lim_ff <= RST_SMOOTH_SLOPE;
         dist_lim_ff   <= RST_DISTORTION;
         span_lim_ff   <= RST_TRI_SPAN;
         drop_lim_ff   <= RST_TRI_DROP;
         tol_ff        <= RST_LINE_TOL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_NOISE_JUMP:   noise_lim_ff  <= csr_wdata[6:0];
            REG_SMOOTH_SLOPE: smooth_lim_ff <= csr_wdata[6:0];
            REG_DISTORTION:   dist_lim_ff   <= csr_wdata[7:0];
            REG_TRI_SPAN:     span_lim_ff   <= csr_wdata[9:0];
            REG_TRI_DROP:     drop_lim_ff   <= csr_wdata[6:0];
            REG_LINE_TOL:     tol_ff        <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_level_ff  <= LEVEL_MID;
         last_delta_ff  <= '0;
         older_delta_ff <= '0;
         noise_sum_ff   <= '0;
         clean_sum_ff   <= '0;
         dist_sum_ff    <= '0;
         linear_sum_ff  <= '0;
         tri_cnt_ff     <= '0;
         sample_idx_ff  <= '0;
         peak_lvl_ff    <= '0;
         trough_lvl_ff  <= LEVEL_TOP;
         peak_idx_ff    <= '0;
         trough_idx_ff  <= '0;
         fall_seen_ff   <= 1'b0;
         last_pend_ff   <= 1'b0;
         walk_issue_ff  <= 1'b0;
         walk_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_level_ff  <= last_level_in;
         last_delta_ff  <= last_delta_in;
         older_delta_ff <= older_delta_in;
         noise_sum_ff   <= noise_sum_in;
         clean_sum_ff   <= clean_sum_in;
         dist_sum_ff    <= dist_sum_in;
         linear_sum_ff  <= linear_sum_in;
         tri_cnt_ff     <= tri_cnt_in;
         sample_idx_ff  <= sample_idx_in;
         peak_lvl_ff    <= peak_lvl_in;
         trough_lvl_ff  <= trough_lvl_in;
         peak_idx_ff    <= peak_idx_in;
         trough_idx_ff  <= trough_idx_in;
         fall_seen_ff   <= fall_seen_in;
         last_pend_ff   <= last_pend_in;
         walk_issue_ff  <= walk_issue_in;
         walk_vld_ff    <= walk_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      t_peak_ff <= t_peak_in;
      t_drop_ff <= t_drop_in;
      walk_k_ff <= walk_k_in;
      y_ff      <= y_in;
      bad_ff    <= bad_in;
   end

   // frame store: sample write port, walk read port
   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_mem[sample_idx_ff[IDX_W-1:0]] <= req_ch.level;
      end
      if (walk_issue_ff) begin
         rd_data_ff <= frame_mem[walk_k_ff];
      end
   end

   // saturated score beat
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_noise_ff  <= (|div_quot[LANE_NOISE][DIV_W-1:NOISE_W]) ? '1
                          : div_quot[LANE_NOISE][NOISE_W-1:0];
         rsp_clean_ff  <= (|div_quot[LANE_CLEAN][DIV_W-1:CLEAN_W]) ? '1
                          : div_quot[LANE_CLEAN][CLEAN_W-1:0];
         rsp_dist_ff   <= (|div_quot[LANE_DIST][DIV_W-1:DIST_W]) ? '1
                          : div_quot[LANE_DIST][DIST_W-1:0];
         rsp_linear_ff <= (|div_quot[LANE_LINEAR][DIV_W-1:LINEAR_W]) ? '1
                          : div_quot[LANE_LINEAR][LINEAR_W-1:0];
         rsp_tri_ff    <= (|div_quot[LANE_TRI][DIV_W-1:TRI_W]) ? '1
                          : div_quot[LANE_TRI][TRI_W-1:0];
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.noise_score      = rsp_noise_ff;
   assign rsp_ch.clean_score      = rsp_clean_ff;
   assign rsp_ch.distortion_score = rsp_dist_ff;
   assign rsp_ch.linear_score     = rsp_linear_ff;
   assign rsp_ch.triangle_score   = rsp_tri_ff;

endmodule

>>> sim/testbench.sv
// self-checking testbench for the waveform character classifier top level
`timescale 1ns / 1ps

module testbench;
   import wcc_pkg::*;

   typedef struct packed {
      logic [NOISE_W-1:0]  noise;
      logic [CLEAN_W-1:0]  clean;
      logic [DIST_W-1:0]   distortion;
      logic [LINEAR_W-1:0] lin;
      logic [TRI_W-1:0]    tri_s;
   } scores_type;

   logic clock;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wcc_req_if req_ch ();
   wcc_rsp_if rsp_ch ();

   waveform_character_classifier_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source)
   );

   // configuration copy
   logic [6:0] cfg_noise_jump, cfg_smooth_slope, cfg_tri_drop, cfg_line_tol;
   logic [7:0] cfg_distortion;
   logic [9:0] cfg_tri_span;

   // classifier state copy
   logic [LEVEL_W-1:0]        prev_level;
   logic signed [DELTA_W-1:0] prev_delta, prior_delta;
   longint                    noise_acc, clean_acc, dist_acc, linear_acc, triangle_acc;
   int                        sample_count;
   logic [LEVEL_W-1:0]        peak_lvl, trough_lvl;
   int                        peak_pos, trough_pos;
   bit                        falling_seen;
   logic [LEVEL_W-1:0]        sample_mem [MAX_FRAME];

   scores_type score_q [$];
   int  error_count = 0;
   int  beats_sent = 0;
   int  frames_sent = 0;
   int  scores_checked = 0;
   int  rsp_stall_left = 0;
   bit  quiet_mode = 0;
   int  cur_level = 50;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int iabs(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit same_sign(int a, int b);
      return (a >= 0 && b >= 0) || (a < 0 && b < 0);
   endfunction

   function automatic void clear_frame_sums();
      noise_acc = 0; clean_acc = 0; dist_acc = 0; linear_acc = 0; triangle_acc = 0;
      sample_count = 0;
      peak_lvl = 0; trough_lvl = LEVEL_TOP; peak_pos = 0; trough_pos = 0;
      falling_seen = 0;
   endfunction

   function automatic void check_fall();
      int span, drop, bad;
      longint slope_q, line_y, tol_q, diff;
      span = trough_pos - peak_pos;
      drop = int'(peak_lvl) - int'(trough_lvl);
      if (span > int'(cfg_tri_span) && drop > int'(cfg_tri_drop) && span > 0) begin
         slope_q = (longint'(drop) << Q16_SHIFT) / span;
         line_y = longint'(peak_lvl) << Q16_SHIFT;
         tol_q = longint'(cfg_line_tol) << Q16_SHIFT;
         bad = 0;
         for (int k = peak_pos; k <= trough_pos && k < MAX_FRAME; k++) begin
            line_y -= slope_q;
            diff = line_y - (longint'(sample_mem[k]) << Q16_SHIFT);
            if (diff < 0) diff = -diff;
            if (diff > tol_q) bad++;
         end
         if (bad < drop / 3) triangle_acc++;
      end
      falling_seen = 0;
      trough_lvl = LEVEL_TOP;
      peak_lvl = 0;
   endfunction

   function automatic void absorb_sample(logic [LEVEL_W-1:0] s);
      int delta, mag, change, ld, od;
      ld = prev_delta;
      od = prior_delta;
      delta = int'(prev_level) - int'(s);
      mag = iabs(delta);
      change = iabs(ld - delta);
      sample_mem[sample_count] = s;
      if (mag > int'(cfg_noise_jump)) noise_acc += mag;
      else if (same_sign(delta, ld)) begin
         if (iabs(ld) <= int'(cfg_smooth_slope) && iabs(od) <= int'(cfg_smooth_slope) &&
             same_sign(delta, od))
            clean_acc += 6;
         else
            clean_acc += 1;
      end
      if (change > int'(cfg_distortion)) dist_acc += change;
      if (delta == ld && ld == od) linear_acc += 3;
      if (s > prev_level && !falling_seen) begin
         peak_pos = sample_count;
         peak_lvl = s;
      end else if (s < prev_level) begin
         trough_pos = sample_count;
         trough_lvl = s;
         falling_seen = 1;
      end else if (s > prev_level) begin
         check_fall();
      end
      prior_delta = prev_delta;
      prev_delta = delta;
      prev_level = s;
   endfunction

   function automatic longint scale_sat(longint sum, int n, int width);
      longint v, lim;
      v = (sum * 1024) / n;
      lim = (longint'(1) << width) - 1;
      return (v > lim) ? lim : v;
   endfunction

   function automatic void predict_beat(logic [LEVEL_W-1:0] s, logic last);
      scores_type exp_s;
      if (sample_count < MAX_FRAME) begin
         absorb_sample(s);
         sample_count++;
      end
      if (last) begin
         exp_s.noise      = NOISE_W'(scale_sat(noise_acc, sample_count, NOISE_W));
         exp_s.clean      = CLEAN_W'(scale_sat(clean_acc, sample_count, CLEAN_W));
         exp_s.distortion = DIST_W'(scale_sat(dist_acc, sample_count, DIST_W));
         exp_s.lin        = LINEAR_W'(scale_sat(linear_acc, sample_count, LINEAR_W));
         exp_s.tri_s      = TRI_W'(scale_sat(triangle_acc, sample_count, TRI_W));
         score_q.push_back(exp_s);
         clear_frame_sums();
      end
   endfunction

   // score beat checker
   always @(posedge clock) begin
      scores_type exp_s;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_stall_left == 0) begin
            rsp_stall_left = quiet_mode ? 0 : $urandom_range(0, 9);
         end
         if (score_q.size() == 0) begin
            $display("%0t: unexpected score beat noise=%0d", $time, rsp_ch.noise_score);
            error_count++;
         end else begin
            exp_s = score_q.pop_front();
            scores_checked++;
            if (rsp_ch.noise_score !== exp_s.noise) begin
               $display("%0t: noise_score expected %0d actual %0d", $time, exp_s.noise,
                        rsp_ch.noise_score);
               error_count++;
            end
            if (rsp_ch.clean_score !== exp_s.clean) begin
               $display("%0t: clean_score expected %0d actual %0d", $time, exp_s.clean,
                        rsp_ch.clean_score);
               error_count++;
            end
            if (rsp_ch.distortion_score !== exp_s.distortion) begin
               $display("%0t: distortion_score expected %0d actual %0d", $time,
                        exp_s.distortion, rsp_ch.distortion_score);
               error_count++;
            end
            if (rsp_ch.linear_score !== exp_s.lin) begin
               $display("%0t: linear_score expected %0d actual %0d", $time, exp_s.lin,
                        rsp_ch.linear_score);
               error_count++;
            end
            if (rsp_ch.triangle_score !== exp_s.tri_s) begin
               $display("%0t: triangle_score expected %0d actual %0d", $time, exp_s.tri_s,
                        rsp_ch.triangle_score);
               error_count++;
            end
         end
      end
   end

   // receiver stall counter
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(int lvl, bit last);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.level <= lvl[6:0];
      req_ch.last_of_frame <= last;
      do @(posedge clock); while (!req_ch.ready);
      predict_beat(lvl[6:0], last);
      beats_sent++;
      if (last) frames_sent++;
      cur_level = lvl;
      @(negedge clock);
   endtask

   task automatic drain_scores();
      req_ch.valid <= 1'b0;
      wait (score_q.size() == 0);
      repeat (1200) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      drain_scores();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_NOISE_JUMP:   cfg_noise_jump = value[6:0];
         REG_SMOOTH_SLOPE: cfg_smooth_slope = value[6:0];
         REG_DISTORTION:   cfg_distortion = value[7:0];
         REG_TRI_SPAN:     cfg_tri_span = value[9:0];
         REG_TRI_DROP:     cfg_tri_drop = value[6:0];
         REG_LINE_TOL:     cfg_line_tol = value[6:0];
         default: ;
      endcase
   endtask

   task automatic write_all(int nj, int ss, int dl, int sp, int dr, int lt);
      write_reg(REG_NOISE_JUMP, nj);
      write_reg(REG_SMOOTH_SLOPE, ss);
      write_reg(REG_DISTORTION, dl);
      write_reg(REG_TRI_SPAN, sp);
      write_reg(REG_TRI_DROP, dr);
      write_reg(REG_LINE_TOL, lt);
   endtask

   function automatic int walk_level(int lvl);
      int v;
      if ($urandom_range(0, 15) == 0) return $urandom_range(0, 127);
      v = lvl + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > 100) v = 100;
      return v;
   endfunction

   // rise to a peak, then a straight fall with a little jitter, then one rising sample
   task automatic send_triangle(int span);
      int peak, drop, v;
      peak = $urandom_range(60, 100);
      drop = $urandom_range(4, 55);
      while (cur_level < peak) begin
         v = cur_level + $urandom_range(3, 9);
         send_beat((v > peak) ? peak : v, 0);
      end
      for (int k = 1; k <= span; k++) begin
         v = peak - (k * drop) / span + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) - 2 : 0);
         if (v < 0) v = 0;
         send_beat(v, 0);
      end
      send_beat(cur_level + $urandom_range(1, 5), 0);
   endtask

   task automatic test_directed();
      int seq [20] = '{50, 50, 50, 0, 100, 127, 101, 64, 1, 0,
                       127, 127, 100, 97, 94, 91, 88, 100, 0, 50};
      for (int i = 0; i < 20; i++) send_beat(seq[i], (i == 8 || i == 9 || i == 19));
      send_beat(127, 1);
   endtask

   task automatic test_triangles(int frames);
      for (int f = 0; f < frames; f++) begin
         repeat ($urandom_range(1, 3)) send_triangle($urandom_range(20, 60));
         send_beat(walk_level(cur_level), 1);
      end
   endtask

   task automatic test_random_frames(int frames);
      for (int f = 0; f < frames; f++) begin
         int len;
         len = $urandom_range(1, 30);
         for (int i = 1; i < len; i++) send_beat(walk_level(cur_level), 0);
         send_beat(walk_level(cur_level), 1);
      end
   endtask

   task automatic test_backpressure();
      @(negedge clock);
      rsp_stall_left = 600;
      quiet_mode = 1;
      for (int f = 0; f < 20; f++) begin
         for (int i = 0; i < 3; i++) send_beat(walk_level(cur_level), 0);
         send_beat(walk_level(cur_level), 1);
      end
      test_random_frames(2);
      quiet_mode = 0;
   endtask

   task automatic test_pause();
      test_random_frames(2);
      req_ch.valid <= 1'b0;
      wait (score_q.size() == 0);
      @(negedge clock);
      test_random_frames(2);
   endtask

   task automatic test_config_sweep();
      write_all(0, 0, 0, 0, 0, 0);
      test_triangles(1);
      test_random_frames(2);
      write_all(100, 100, 200, 1023, 100, 100);
      test_random_frames(2);
      test_triangles(1);
      write_reg(3'd6, 1023);
      write_reg(3'd7, 0);
      write_all(3, 1, 6, 10, 5, 0);
      test_triangles(1);
      write_all($urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 200),
                $urandom_range(0, 60), $urandom_range(0, 100), $urandom_range(0, 100));
      test_random_frames(2);
      write_all(5, 3, 3, 30, 3, 2);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.level = '0;
      req_ch.last_of_frame = 1'b0;
      cfg_noise_jump = RST_NOISE_JUMP;
      cfg_smooth_slope = RST_SMOOTH_SLOPE;
      cfg_distortion = RST_DISTORTION;
      cfg_tri_span = RST_TRI_SPAN;
      cfg_tri_drop = RST_TRI_DROP;
      cfg_line_tol = RST_LINE_TOL;
      prev_level = LEVEL_MID;
      prev_delta = 0;
      prior_delta = 0;
      clear_frame_sums();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_triangles(2);
      test_random_frames(4);
      test_backpressure();
      test_pause();
      test_config_sweep();
      while (beats_sent < 750) begin
         if ($urandom_range(0, 2) == 0) test_random_frames(1);
         else test_triangles(1);
         if ($urandom_range(0, 3) == 0) begin
            quiet_mode = ~quiet_mode;
         end
      end
      quiet_mode = 0;

      req_ch.valid <= 1'b0;
      wait (score_q.size() == 0);
      repeat (1200) @(posedge clock);
      $display("covered %0d sample beats in %0d frames, %0d score beats checked,",
               beats_sent, frames_sent, scores_checked);
      $display("with register sweeps, straight falling slopes and a long receiver hold-off");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/wcc_pkg.sv
rtl/wcc_if.sv
rtl/wcc_divider.sv
rtl/waveform_character_classifier_top.sv
sim/testbench.sv
